// ===== rtl/macd_pkg.sv =====
// shared types and constants of the macd filter bank
// widths, register codes and reset values; no dependencies
package macd_pkg;

  localparam int PRICE_WIDTH    = 32;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_W         = COEF_FRAC_BITS + 1;

  // signed operand of the shared unit: price, average, macd or signal
  localparam int OPND_W = PRICE_WIDTH + 1;
  // difference of two operands
  localparam int DIFF_W = PRICE_WIDTH + 2;
  // product of difference and zero-extended weight
  localparam int PROD_W = DIFF_W + COEF_W + 1;
  // weighted step after the Q shift, and the updated sum
  localparam int SUM_W  = PROD_W - COEF_FRAC_BITS;
  localparam int HIST_W = PRICE_WIDTH + 2;

  localparam int OUT_FIELDS_W = 2 * OPND_W + HIST_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;
  localparam int IN_DATA_W    = ((PRICE_WIDTH + 7) / 8) * 8;

  localparam logic signed [SUM_W-1:0] SUM_HI =
    SUM_W'((64'd1 << PRICE_WIDTH) - 64'd1);
  localparam logic signed [SUM_W-1:0] SUM_LO_SIGNED = ~SUM_HI;

  // register indexes
  localparam logic [1:0] CFG_FAST   = 2'd0;
  localparam logic [1:0] CFG_SLOW   = 2'd1;
  localparam logic [1:0] CFG_SIGNAL = 2'd2;

  localparam logic [COEF_W-1:0] FAST_COEF_RESET   = COEF_W'(10082);
  localparam logic [COEF_W-1:0] SLOW_COEF_RESET   = COEF_W'(4855);
  localparam logic [COEF_W-1:0] SIGNAL_COEF_RESET = COEF_W'(13107);

  // control of one update issued to the shared unit
  typedef struct packed {
    logic load;        // capture operands and product this cycle
    logic sat_signed;  // saturate to the signed range instead of the price range
  } issue_t;

endpackage

// ===== rtl/macd_ema_unit.sv =====
// shared average update unit: avg + floor((target - avg) * coef / 2^q), saturated
// registers the product, result valid the cycle after issue; uses macd_pkg
module macd_ema_unit (
  input  logic                                   clk_i,
  input  macd_pkg::issue_t                       issue_i,
  input  logic signed [macd_pkg::OPND_W-1:0]     avg_i,
  input  logic signed [macd_pkg::OPND_W-1:0]     target_i,
  input  logic        [macd_pkg::COEF_W-1:0]     coef_i,
  output logic signed [macd_pkg::OPND_W-1:0]     result_o
);

  logic signed [macd_pkg::DIFF_W-1:0] diff;
  logic signed [macd_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [macd_pkg::OPND_W-1:0] avg_q;
  logic                               sat_signed_q;
  logic signed [macd_pkg::SUM_W-1:0]  step, sum, lo;

  assign diff   = macd_pkg::DIFF_W'(target_i) - macd_pkg::DIFF_W'(avg_i);
  assign prod_d = macd_pkg::PROD_W'(diff) * $signed({1'b0, coef_i});

  always_ff @(posedge clk_i) begin
    if (issue_i.load) begin
      prod_q       <= prod_d;
      avg_q        <= avg_i;
      sat_signed_q <= issue_i.sat_signed;
    end
  end

  // dropping the fraction bits is the floor shift
  assign step = prod_q[macd_pkg::PROD_W-1:macd_pkg::COEF_FRAC_BITS];
  assign sum  = macd_pkg::SUM_W'(avg_q) + step;
  assign lo   = sat_signed_q ? macd_pkg::SUM_LO_SIGNED : '0;

  always_comb begin
    if (sum > macd_pkg::SUM_HI) begin
      result_o = macd_pkg::OPND_W'(macd_pkg::SUM_HI);
    end else if (sum < lo) begin
      result_o = macd_pkg::OPND_W'(lo);
    end else begin
      result_o = sum[macd_pkg::OPND_W-1:0];
    end
  end

endmodule

// ===== rtl/macd_ema_filter_bank.sv =====
// top level of the macd filter bank: stream ports, weight registers and sequencer
// depends on macd_pkg and macd_ema_unit
//
// A sample marked series_start loads both price averages in the cycle it is accepted and
// gives no result, so the next sample can be taken in the following cycle. Any other sample
// has its result loaded into the output register through the steps below. The fast
// update is issued to the single shared multiplier in the accepting cycle. The slow update is
// issued in the cycle that writes back the fast average. After that come the slow write-back
// and the macd difference. The signal line takes an issue step and a write-back step, and
// then the output step loads the output register. On the first macd of a series the signal
// update is skipped, which leaves out the signal write-back step. s_axis_tready is high only
// while the sequencer is idle and returns the cycle after the output register is loaded. A
// new sample is therefore taken only once the result of the last one is in the output
// register. The result stays in the output register until taken, and a result still waiting
// there holds the sequencer before it loads the next one.
module macd_ema_filter_bank (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // weight registers
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [1:0]                            cfg_index_i,
  input  logic [macd_pkg::COEF_W-1:0]           cfg_data_i,
  // samples
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [macd_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // close_price
  input  logic                                  s_axis_tuser,  // series_start
  input  logic                                  s_axis_tlast,  // last_sample
  // results
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // macd_value, signal_value, histogram_value, zero pad
  output logic [macd_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic                                  m_axis_tlast   // end_of_series
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FAST = 3'd1;
  localparam logic [2:0] ST_SLOW = 3'd2;
  localparam logic [2:0] ST_MACD = 3'd3;
  localparam logic [2:0] ST_SIGI = 3'd4;
  localparam logic [2:0] ST_SIG  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  localparam int PW = macd_pkg::PRICE_WIDTH;
  localparam int OW = macd_pkg::OPND_W;

  logic [2:0] state_q, state_d;

  logic [macd_pkg::COEF_W-1:0] fast_coef_q, slow_coef_q, signal_coef_q;
  logic [PW-1:0]               fast_q, slow_q, price_q;
  logic signed [OW-1:0]        sig_q, macd_q;
  logic                        loaded_q, last_q;

  logic                           out_valid_q;
  logic signed [OW-1:0]           out_macd_q, out_sig_q;
  logic signed [macd_pkg::HIST_W-1:0] out_hist_q;
  logic                           out_last_q;

  macd_pkg::issue_t               issue;
  logic signed [OW-1:0]           unit_avg, unit_target, unit_result;
  logic [macd_pkg::COEF_W-1:0]    unit_coef;

  logic in_fire, out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_coef_q   <= macd_pkg::FAST_COEF_RESET;
      slow_coef_q   <= macd_pkg::SLOW_COEF_RESET;
      signal_coef_q <= macd_pkg::SIGNAL_COEF_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        macd_pkg::CFG_FAST:   fast_coef_q   <= cfg_data_i;
        macd_pkg::CFG_SLOW:   slow_coef_q   <= cfg_data_i;
        macd_pkg::CFG_SIGNAL: signal_coef_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // operand selection for the shared unit
  always_comb begin
    issue       = '0;
    unit_avg    = OW'({1'b0, fast_q});
    unit_target = OW'({1'b0, s_axis_tdata[PW-1:0]});
    unit_coef   = fast_coef_q;
    unique case (state_q)
      ST_IDLE: begin
        issue.load = in_fire && !s_axis_tuser;
      end
      ST_FAST: begin
        issue.load  = 1'b1;
        unit_avg    = OW'({1'b0, slow_q});
        unit_target = OW'({1'b0, price_q});
        unit_coef   = slow_coef_q;
      end
      ST_SIGI: begin
        issue.load       = loaded_q;
        issue.sat_signed = 1'b1;
        unit_avg         = sig_q;
        unit_target      = macd_q;
        unit_coef        = signal_coef_q;
      end
      default: ;
    endcase
  end

  macd_ema_unit u_ema (
    .clk_i    (clk_i),
    .issue_i  (issue),
    .avg_i    (unit_avg),
    .target_i (unit_target),
    .coef_i   (unit_coef),
    .result_o (unit_result)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire && !s_axis_tuser) state_d = ST_FAST;
      ST_FAST: state_d = ST_SLOW;
      ST_SLOW: state_d = ST_MACD;
      ST_MACD: state_d = ST_SIGI;
      ST_SIGI: state_d = loaded_q ? ST_SIG : ST_OUT;
      ST_SIG:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fast_q      <= '0;
      slow_q      <= '0;
      sig_q       <= '0;
      loaded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && s_axis_tuser) begin
            fast_q   <= s_axis_tdata[PW-1:0];
            slow_q   <= s_axis_tdata[PW-1:0];
            sig_q    <= '0;
            loaded_q <= 1'b0;
          end
        end
        ST_FAST: fast_q <= unit_result[PW-1:0];
        ST_SLOW: slow_q <= unit_result[PW-1:0];
        ST_SIGI: begin
          if (!loaded_q) begin
            // first macd of a series seeds the signal line
            sig_q    <= macd_q;
            loaded_q <= 1'b1;
          end
        end
        ST_SIG:  sig_q <= unit_result;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      price_q <= s_axis_tdata[PW-1:0];
      last_q  <= s_axis_tlast;
    end
    if (state_q == ST_MACD) begin
      macd_q <= OW'({1'b0, fast_q}) - OW'({1'b0, slow_q});
    end
    if (state_q == ST_OUT && out_free) begin
      out_macd_q <= macd_q;
      out_sig_q  <= sig_q;
      out_hist_q <= macd_pkg::HIST_W'(macd_q) - macd_pkg::HIST_W'(sig_q);
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{macd_pkg::OUT_PAD_W{1'b0}}, out_hist_q, out_sig_q, out_macd_q};
  assign m_axis_tlast  = out_last_q;

endmodule
